// File: src/bimode_branch_predictor_core_defines.svh
// Assertion macros used by the predictor core.
`ifndef BIMODE_BRANCH_PREDICTOR_CORE_DEFINES_SVH
`define BIMODE_BRANCH_PREDICTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BMBP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define BMBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/bmbp_pkg.sv
package bmbp_pkg;

    // Default table sizes, as index widths.
    localparam int CHOICE_INDEX_BITS    = 12;
    localparam int DIRECTION_INDEX_BITS = 12;

    // Command codes.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Saturation limits of a 2-bit counter.
    localparam logic [1:0] CTR_MAX = 2'd3;
    localparam logic [1:0] CTR_MIN = 2'd0;

    // Input beat.
    typedef struct packed {
        logic        command;
        logic [31:0] pc;
        logic [15:0] history;
        logic [15:0] direction_index;
        logic        predicted;
        logic        taken;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic        prediction;
        logic [15:0] index_out;
        logic [31:0] branch_count;
        logic [31:0] mispredict_count;
    } out_t;

endpackage

// File: src/bmbp_ram.sv
module bmbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds without re.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bimode_branch_predictor_core.sv
// Bi-mode branch predictor. Each beat is a predict or an update and yields
// exactly one result beat. In the cycle in which an item is accepted, its
// table indexes go to the synchronous reads. In the lookup state that follows,
// the counters are read and, for an update, trained and written back, and the
// result is loaded into the output register. A new item is not taken until the
// last one has been loaded there. A finished result waits in the output
// register while the next item is accepted. That item then holds in its lookup
// state, and the input stalls, until the output register is free. After reset a
// clearing pass zeroes all tables, during which no item is accepted.
`include "bimode_branch_predictor_core_defines.svh"

module bimode_branch_predictor_core #(
    parameter int CHOICE_INDEX_BITS    = bmbp_pkg::CHOICE_INDEX_BITS,
    parameter int DIRECTION_INDEX_BITS = bmbp_pkg::DIRECTION_INDEX_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bmbp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bmbp_pkg::out_t m_data
);

    localparam int CIB      = CHOICE_INDEX_BITS;
    localparam int DIB      = DIRECTION_INDEX_BITS;
    localparam int CLR_BITS = (CIB > DIB) ? CIB : DIB;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t               state_reg;
    logic [CLR_BITS-1:0]  clr_cnt_reg;
    logic                 cmd_reg;
    logic                 predicted_reg;
    logic                 taken_reg;
    logic [CIB-1:0]       c_idx_reg;
    logic [DIB-1:0]       d_idx_reg;
    logic [31:0]          branch_cnt_reg;
    logic [31:0]          mispred_cnt_reg;
    logic                 m_valid_reg;
    bmbp_pkg::out_t       m_data_reg;

    logic                 accept;
    logic                 out_load;
    logic [CIB-1:0]       c_idx_next;
    logic [DIB-1:0]       d_idx_next;
    logic [1:0]           choice_rdata;
    logic [3:0]           dir_rdata;
    logic                 choose_taken;
    logic [1:0]           sel_ctr;
    logic [1:0]           sel_new;
    logic                 skip_choice;
    logic [1:0]           choice_new;
    logic [3:0]           dir_new;
    logic                 ram_we;
    logic [CIB-1:0]       choice_waddr;
    logic [DIB-1:0]       dir_waddr;
    logic [1:0]           choice_wdata;
    logic [3:0]           dir_wdata;
    logic [31:0]          branch_cnt_next;
    logic [31:0]          mispred_cnt_next;
    bmbp_pkg::out_t       result;

    // Saturating 2-bit counter step.
    function automatic logic [1:0] train(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        res = ctr;
        if (up) begin
            if (ctr != bmbp_pkg::CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != bmbp_pkg::CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

    // Handshake and table indexes of the incoming beat.
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_load   = (state_reg == ST_LOOKUP) && (!m_valid_reg || m_ready);
    assign c_idx_next = s_data.pc[2 +: CIB];
    assign d_idx_next = (s_data.command == bmbp_pkg::CMD_UPDATE)
                      ? s_data.direction_index[DIB-1:0]
                      : (s_data.pc[2 +: DIB] ^ s_data.history[DIB-1:0]);

    // Choice table and direction tables; the direction word holds the
    // taken counter in the upper half and the not-taken counter below.
    bmbp_ram #(.WIDTH(2), .DEPTH(1 << CIB)) u_choice_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (choice_waddr),
        .wdata (choice_wdata),
        .re    (accept),
        .raddr (c_idx_next),
        .rdata (choice_rdata)
    );

    bmbp_ram #(.WIDTH(4), .DEPTH(1 << DIB)) u_dir_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (accept),
        .raddr (d_idx_next),
        .rdata (dir_rdata)
    );

    // Prediction and training from the read data.
    always_comb begin
        choose_taken = choice_rdata[1];
        sel_ctr      = choose_taken ? dir_rdata[3:2] : dir_rdata[1:0];
        sel_new      = train(sel_ctr, taken_reg);
        // The choice is left alone when it was wrong but the chosen counter was right.
        skip_choice  = (sel_ctr[1] == taken_reg) && (choose_taken != taken_reg);
        choice_new   = skip_choice ? choice_rdata : train(choice_rdata, taken_reg);
        dir_new      = choose_taken ? {sel_new, dir_rdata[1:0]} : {dir_rdata[3:2], sel_new};
    end

    // Write port: clearing pass, or write-back of an update.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we       = 1'b1;
            choice_waddr = clr_cnt_reg[CIB-1:0];
            dir_waddr    = clr_cnt_reg[DIB-1:0];
            choice_wdata = 2'd0;
            dir_wdata    = 4'd0;
        end else begin
            ram_we       = out_load && (cmd_reg == bmbp_pkg::CMD_UPDATE);
            choice_waddr = c_idx_reg;
            dir_waddr    = d_idx_reg;
            choice_wdata = choice_new;
            dir_wdata    = dir_new;
        end
    end

    // Statistics and the result beat.
    always_comb begin
        branch_cnt_next  = branch_cnt_reg;
        mispred_cnt_next = mispred_cnt_reg;
        result           = '0;
        if (cmd_reg == bmbp_pkg::CMD_UPDATE) begin
            branch_cnt_next = branch_cnt_reg + 32'd1;
            if (predicted_reg != taken_reg) begin
                mispred_cnt_next = mispred_cnt_reg + 32'd1;
            end
        end else begin
            result.prediction = sel_ctr[1];
            result.index_out  = 16'(d_idx_reg);
        end
        result.branch_count     = branch_cnt_next;
        result.mispredict_count = mispred_cnt_next;
    end

    // Sequencer, item registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            branch_cnt_reg  <= '0;
            mispred_cnt_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg       <= s_data.command;
                        predicted_reg <= s_data.predicted;
                        taken_reg     <= s_data.taken;
                        c_idx_reg     <= c_idx_next;
                        d_idx_reg     <= d_idx_next;
                        state_reg     <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (out_load) begin
                        branch_cnt_reg  <= branch_cnt_next;
                        mispred_cnt_reg <= mispred_cnt_next;
                        m_data_reg      <= result;
                        m_valid_reg     <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted beat always moves on to the table lookup.
    `BMBP_ASSERT_NEXT(a_accept_lookup, aclk, aresetn, accept, state_reg == ST_LOOKUP)
    // Statistics move only when an update result is loaded.
    `BMBP_ASSERT_NEXT(a_cnt_stable, aclk, aresetn, !(out_load && (cmd_reg == bmbp_pkg::CMD_UPDATE)), $stable(branch_cnt_reg) && $stable(mispred_cnt_reg))
    // While the tables are being cleared no result leaves and every cycle writes.
    `BMBP_ASSERT_NOW(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR, !m_valid_reg && ram_we)

endmodule
